@@ rtl/core/pidc_pkg.sv @@
// pidc_pkg: shared widths, register indexes and sequencer states
// for the clamped-integrator pid controller; no dependencies
`default_nettype none

package pidc_pkg;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int GAIN_W      = 16;
  localparam int BOUND_W     = 32;
  localparam int ELAPSED_W   = 16;
  localparam int DRIVE_W     = 32;

  localparam int DEF_SAMPLE_WIDTH       = 16;
  localparam int DEF_GAIN_FRACTION_BITS = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_INTEG_FLOOR   = 3'd4,
    REG_INTEG_CEILING = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_P,
    S_MUL_DT,
    S_CLAMP,
    S_MUL_I,
    S_ADD_I,
    S_WAIT_DIV,
    S_FINISH
  } pidc_state_t;

endpackage

`default_nettype wire

@@ rtl/core/pidc_mul.sv @@
// pidc_mul: shared signed multiplier with registered product
// depends on nothing but its width parameters
`default_nettype none

module pidc_mul #(
  parameter int A_W = 32,
  parameter int B_W = 17
) (
  input  wire logic                      clk,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output      logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

@@ rtl/core/pidc_div.sv @@
// pidc_div: restoring divider, signed dividend by unsigned divisor,
// one quotient bit a cycle, result truncated toward zero
`default_nettype none

module pidc_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output      logic                    busy,
  output      logic signed [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic             neg;
  logic [NUM_W-1:0] work;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_next;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem[DEN_W-1:0], work[NUM_W-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    rem_next = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      work  <= num[NUM_W-1] ? NUM_W'(-num) : num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[NUM_W-2:0], qbit};
    end
  end

  // magnitude back to signed
  assign quot = neg ? NUM_W'(-work) : work;

endmodule

`default_nettype wire

@@ rtl/core/pid_controller_clamped_integrator.sv @@
// pid_controller_clamped_integrator: top level, sequencer and datapath
// depends on pidc_pkg, pidc_mul, pidc_div
//
// usage
//   config port: cfg_write with cfg_index and cfg_data writes one register in a cycle
//     (0 setpoint, 1..3 gains p/i/d in q8.8, 4 integrator floor, 5 integrator ceiling);
//     a setpoint write also clears the integrator and the last error; other indexes ignored
//   input request: measured and elapsed, taken when in_valid is high and in_stall low
//   output request: drive and error_now, taken when out_valid is high and out_stall low
//   the bit-serial derivative divider, one quotient bit a cycle over GAIN_W + SAMPLE_WIDTH
//     + 2 bits, sets how long a request takes; it runs while the shared multiplier does
//     its products after the derivative one
//   in_stall stays high from acceptance until the result is loaded into the output register
//   a finished result waits in the output register while out_stall is high; the next
//     request is accepted meanwhile, and the sequencer holds its following result until
//     the output register is free
//   reset: synchronous, active high; clears registers, integrator, last error and valid
`default_nettype none

module pid_controller_clamped_integrator
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = DEF_SAMPLE_WIDTH,
  parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
  input  wire logic [ELAPSED_W-1:0]          elapsed,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [DRIVE_W-1:0]     drive,
  output      logic signed [SAMPLE_WIDTH:0]  error_now
);

  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIFF_W = SAMPLE_WIDTH + 2;
  localparam int MA_W   = (DIFF_W > BOUND_W) ? DIFF_W : BOUND_W;
  localparam int MB_W   = GAIN_W + 1;
  localparam int MP_W   = MA_W + MB_W;
  localparam int ND_W   = GAIN_W + DIFF_W;
  localparam int TOT_W  = MP_W + 2;
  localparam int ACC_W  = MP_W + 1;

  // configuration registers
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [GAIN_W-1:0]       gain_p;
  logic signed [GAIN_W-1:0]       gain_i;
  logic signed [GAIN_W-1:0]       gain_d;
  logic signed [BOUND_W-1:0]      integ_floor;
  logic signed [BOUND_W-1:0]      integ_ceiling;

  // controller state
  logic signed [ERR_W-1:0]   prior_error;
  logic signed [BOUND_W-1:0] integral_sum;

  // per-request working registers
  pidc_state_t               state, state_next;
  logic signed [ERR_W-1:0]   err;
  logic [ELAPSED_W-1:0]      dt;
  logic signed [TOT_W-1:0]   total;

  // shared multiplier and divider hookup
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic                   div_start;
  logic                   div_busy;
  logic signed [ND_W-1:0] div_quot;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [ACC_W-1:0]    integ_acc;
  logic signed [BOUND_W-1:0]  integ_clamped;
  logic signed [TOT_W-1:0]    shifted;
  logic [TOT_W-DRIVE_W:0]     shifted_hi;
  logic signed [DRIVE_W-1:0]  drive_sat;
  logic                       load_out;

  pidc_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // derivative product is registered from the S_MUL_D operands and ready in the next state, S_MUL_P
  pidc_div #(
    .NUM_W (ND_W),
    .DEN_W (ELAPSED_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[ND_W-1:0]),
    .den   (dt),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign diff = DIFF_W'(err) - DIFF_W'(prior_error);

  // integrator update with ceiling checked first
  always_comb begin
    integ_acc = ACC_W'(integral_sum) + ACC_W'(prod);
    if (integ_acc > ACC_W'(integ_ceiling)) begin
      integ_clamped = integ_ceiling;
    end else if (integ_acc < ACC_W'(integ_floor)) begin
      integ_clamped = integ_floor;
    end else begin
      integ_clamped = integ_acc[BOUND_W-1:0];
    end
  end

  // drop fraction bits (floor) and saturate to the drive width
  always_comb begin
    shifted    = total >>> GAIN_FRACTION_BITS;
    shifted_hi = shifted[TOT_W-1:DRIVE_W-1];
    if ((&shifted_hi) || !(|shifted_hi)) begin
      drive_sat = shifted[DRIVE_W-1:0];
    end else if (shifted[TOT_W-1]) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and operand steering for the shared units
  always_comb begin
    state_next = state;
    mul_a      = MA_W'(err);
    mul_b      = MB_W'(gain_p);
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MUL_D;
        end
      end
      S_MUL_D: begin
        mul_a      = MA_W'(diff);
        mul_b      = MB_W'(gain_d);
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        div_start  = 1'b1;
        state_next = S_MUL_DT;
      end
      S_MUL_DT: begin
        mul_b      = MB_W'({1'b0, dt});
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        state_next = S_MUL_I;
      end
      S_MUL_I: begin
        mul_a      = MA_W'(integral_sum);
        mul_b      = MB_W'(gain_i);
        state_next = S_ADD_I;
      end
      S_ADD_I: begin
        state_next = S_WAIT_DIV;
      end
      S_WAIT_DIV: begin
        if (!div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        err <= ERR_W'(setpoint) - ERR_W'(measured);
        dt  <= elapsed;
      end
      S_MUL_DT: begin
        total <= TOT_W'(prod);  // proportional term
      end
      S_ADD_I: begin
        total <= total + TOT_W'(prod);  // integral term
      end
      S_WAIT_DIV: begin
        // zero elapsed contributes no derivative term
        if (!div_busy && (dt != '0)) begin
          total <= total + TOT_W'(div_quot);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      integ_floor   <= '0;
      integ_ceiling <= '0;
      prior_error   <= '0;
      integral_sum  <= '0;
    end else begin
      if (state == S_CLAMP) begin
        integral_sum <= integ_clamped;
        prior_error  <= err;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SETPOINT: begin
            setpoint     <= cfg_data[SAMPLE_WIDTH-1:0];
            integral_sum <= '0;
            prior_error  <= '0;
          end
          REG_GAIN_P:        gain_p        <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:        gain_i        <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:        gain_d        <= cfg_data[GAIN_W-1:0];
          REG_INTEG_FLOOR:   integ_floor   <= cfg_data[BOUND_W-1:0];
          REG_INTEG_CEILING: integ_ceiling <= cfg_data[BOUND_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive     <= drive_sat;
      error_now <= err;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pidc_checker.sv @@
// pidc_checker: port-level assertions for the pid controller top level
// depends on pidc_pkg; bound to pid_controller_clamped_integrator below
`default_nettype none

module pidc_checker
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic signed [DRIVE_W-1:0]    drive,
  input wire logic signed [SAMPLE_WIDTH:0] error_now
);

  // reset empties the output register
  a_reset_clears_out : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // an accepted request keeps the block busy
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a request");

  // a fresh result only comes out of a request in progress
  a_result_from_work : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(drive) && $stable(error_now)))
    else $error("stalled result changed");

endmodule

bind pid_controller_clamped_integrator pidc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pidc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .error_now (error_now)
);

`default_nettype wire
